@@ design/lwm_pkg.sv @@
package lwm_pkg;

  typedef enum logic [1:0] {
    ActClear  = 2'd0,
    ActAppend = 2'd1,
    ActText   = 2'd2,
    ActEnd    = 2'd3
  } action_e;

  localparam logic [7:0] CharAnyRun = 8'h25;
  localparam logic [7:0] CharAnyOne = 8'h5F;

  typedef logic [7:0] char_t;

endpackage

@@ design/lwm_nfa_step.sv @@
module lwm_nfa_step
  import lwm_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  logic [MAX_PATTERN:0]   active_i,
  input  logic [MAX_PATTERN-1:0] valid_i,
  input  char_t                  store_i [MAX_PATTERN],
  input  char_t                  char_i,
  output logic [MAX_PATTERN:0]   next_o
);

  localparam int W  = MAX_PATTERN + 1;
  localparam int Lv = (W > 1) ? $clog2(W) : 1;

  logic [MAX_PATTERN-1:0] is_run;
  logic [MAX_PATTERN-1:0] stay;
  logic [MAX_PATTERN-1:0] adv;
  logic [W-1:0]           gen [Lv+1];
  logic [W-1:0]           prop [Lv+1];

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      is_run[j] = valid_i[j] && (store_i[j] == CharAnyRun);
      stay[j]   = active_i[j] && is_run[j];
      adv[j]    = active_i[j] && valid_i[j] && !is_run[j] &&
                  ((store_i[j] == CharAnyOne) || (store_i[j] == char_i));
    end
  end

  // Spread liveness forward through runs of '%' as a prefix scan.
  always_comb begin
    int d;
    gen[0]  = {1'b0, stay} | {adv, 1'b0};
    prop[0] = {is_run, 1'b0};
    for (int l = 0; l < Lv; l++) begin
      d = 1 << l;
      for (int j = 0; j < W; j++) begin
        if (j >= d) begin
          gen[l+1][j]  = gen[l][j] | (prop[l][j] & gen[l][j-d]);
          prop[l+1][j] = prop[l][j] & prop[l][j-d];
        end else begin
          gen[l+1][j]  = gen[l][j];
          prop[l+1][j] = prop[l][j];
        end
      end
    end
    next_o = gen[Lv] & (prop[Lv] | ~prop[Lv]);
  end

endmodule

@@ design/like_wildcard_matcher_top.sv @@
// Channel   Dir  Beat content
// s_axis    in   tdata[7:0] char_code; tuser[1:0] action
// m_axis    out  tdata[0] matched (rest zero); tuser[0] status
// cfg       in   cfg_data_i[0] invert_result
//
// One input beat per cycle while tready is high; actions complete when taken.
// An end-of-text beat shows its result on m_axis in the next cycle.
// The NFA update with '%' closure is a single prefix scan over the positions.
// Input is taken while the output register is empty or being drained.
// Reset clears pattern length, overflow and output; no clearing pass.
module like_wildcard_matcher_top
  import lwm_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic [1:0] s_axis_tuser,   // [1:0] action
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] matched, [7:1] zero
  output logic       m_axis_tuser,   // [0] status
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  localparam int N = MAX_PATTERN;

  char_t          store_q [N];
  logic [N-1:0]   valid_q, valid_d;
  logic [N:0]     active_q, active_d;
  logic [N:0]     base_q, base_d;
  logic           ovf_q, ovf_d;
  logic           invert_q;
  logic           out_valid_q;
  logic           matched_q, matched_d;
  logic           status_q;

  logic           take;
  action_e        action;
  char_t          chr;
  logic [N:0]     valid_ext;
  logic [N-1:0]   wr_sel;
  logic           full;
  logic [N:0]     end_sel;
  logic [N:0]     next_act;
  logic [N:0]     base_grow;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign action        = action_e'(s_axis_tuser);
  assign chr           = s_axis_tdata;
  assign cfg_ready_o   = 1'b1;

  assign valid_ext = {valid_q, 1'b1};
  assign wr_sel    = valid_ext[N-1:0] & ~valid_q;
  assign full      = valid_q[N-1];
  assign end_sel   = {valid_q, 1'b1} & ~{1'b0, valid_q};

  always_comb begin
    base_grow = base_q;
    for (int j = 0; j < N; j++) begin
      if (base_q[j] && wr_sel[j] && (chr == CharAnyRun)) begin
        base_grow[j+1] = 1'b1;
      end
    end
  end

  lwm_nfa_step #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_step (
    .active_i(active_q),
    .valid_i (valid_q),
    .store_i (store_q),
    .char_i  (chr),
    .next_o  (next_act)
  );

  always_comb begin
    valid_d   = valid_q;
    base_d    = base_q;
    ovf_d     = ovf_q;
    active_d  = active_q;
    matched_d = !ovf_q && ((|(active_q & end_sel)) ^ invert_q);
    if (take) begin
      unique case (action)
        ActClear: begin
          valid_d  = '0;
          base_d   = (N+1)'(1);
          ovf_d    = 1'b0;
          active_d = (N+1)'(1);
        end
        ActAppend: begin
          if (full) begin
            ovf_d    = 1'b1;
            active_d = base_q;
          end else begin
            valid_d  = valid_ext[N-1:0];
            base_d   = base_grow;
            active_d = base_grow;
          end
        end
        ActText: begin
          active_d = next_act;
        end
        ActEnd: begin
          active_d = base_q;
        end
        default: begin
          active_d = active_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < N; j++) begin
      if (take && (action == ActAppend) && wr_sel[j]) begin
        store_q[j] <= chr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      base_q      <= (N+1)'(1);
      active_q    <= (N+1)'(1);
      ovf_q       <= 1'b0;
      invert_q    <= 1'b0;
      out_valid_q <= 1'b0;
      matched_q   <= 1'b0;
      status_q    <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      base_q   <= base_d;
      active_q <= active_d;
      ovf_q    <= ovf_d;
      if (cfg_valid_i) begin
        invert_q <= cfg_data_i;
      end
      if (take && (action == ActEnd)) begin
        out_valid_q <= 1'b1;
        matched_q   <= matched_d;
        status_q    <= ovf_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, matched_q};
  assign m_axis_tuser  = status_q;

endmodule

@@ verif/like_match_checker.sv @@
module like_match_checker
  import lwm_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic [1:0] s_axis_tuser,
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,
  input  logic       m_axis_tuser,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_o,
  input  logic       cfg_data_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         verdicts_o
);

  typedef struct packed {
    logic matched;
    logic status;
  } verdict_t;

  char_t                pat_mem [MAX_PATTERN];
  int unsigned          pat_len;
  logic [MAX_PATTERN:0] live;
  logic                 ovf;
  logic                 invert;
  verdict_t             verdict_q [$];
  int                   fail_count = 0;
  int                   pending = 0;
  int                   verdicts = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign verdicts_o   = verdicts;

  // Spread liveness through '%' positions, which may match an empty run.
  function automatic logic [MAX_PATTERN:0] spread_runs(logic [MAX_PATTERN:0] s);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i < pat_len && s[i] && pat_mem[i] == CharAnyRun) begin
        s[i+1] = 1'b1;
      end
    end
    return spread_runs_done(s);
  endfunction

  function automatic logic [MAX_PATTERN:0] spread_runs_done(logic [MAX_PATTERN:0] s);
    return s;
  endfunction

  function automatic logic [MAX_PATTERN:0] start_set();
    logic [MAX_PATTERN:0] s;
    s = '0;
    s[0] = 1'b1;
    return spread_runs(s);
  endfunction

  function automatic logic [MAX_PATTERN:0] step_byte(char_t c);
    logic [MAX_PATTERN:0] nxt;
    nxt = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i < pat_len && live[i]) begin
        if (pat_mem[i] == CharAnyRun) begin
          nxt[i] = 1'b1;
        end else if (pat_mem[i] == CharAnyOne || pat_mem[i] == c) begin
          nxt[i+1] = 1'b1;
        end
      end
    end
    return spread_runs(nxt);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    logic     hit;
    if (!rst_ni) begin
      pat_len = 0;
      ovf     = 1'b0;
      invert  = 1'b0;
      live    = '0;
      live[0] = 1'b1;
      verdict_q.delete();
      pending = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with no verdict pending: matched=%0b status=%0b",
                 m_axis_tdata[0], m_axis_tuser);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          verdicts++;
          if (m_axis_tdata[0] !== want.matched) begin
            $error("matched: expected %0b, got %0b", want.matched, m_axis_tdata[0]);
            fail_count++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tdata[7:1] !== 7'd0) begin
            $error("tdata padding: expected 0, got %0h", m_axis_tdata[7:1]);
            fail_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        invert = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          ActClear: begin
            pat_len = 0;
            ovf     = 1'b0;
            live    = start_set();
          end
          ActAppend: begin
            if (pat_len < MAX_PATTERN) begin
              pat_mem[pat_len] = s_axis_tdata;
              pat_len++;
            end else begin
              ovf = 1'b1;
            end
            live = start_set();
          end
          ActText: begin
            live = step_byte(s_axis_tdata);
          end
          default: begin
            hit = live[pat_len];
            if (invert) begin
              hit = !hit;
            end
            if (ovf) begin
              hit = 1'b0;
            end
            want.matched = hit;
            want.status  = ovf;
            verdict_q    = {verdict_q, want};
            live = start_set();
          end
        endcase
      end
      pending = verdict_q.size();
    end
  end

endmodule

@@ verif/tb_like_wildcard_matcher_top.sv @@
module tb_like_wildcard_matcher_top;
  import lwm_pkg::*;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'd0;
  logic [1:0] s_axis_tuser  = ActClear;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_data_i    = 1'b0;
  int         fail_count_o;
  int         pending_o;
  int         verdicts_o;

  int         beats_sent    = 0;
  int         settings_used = 0;
  bit         tx_burst      = 1'b0;
  bit         rx_burst      = 1'b0;

  always #6 clk_i = ~clk_i;

  like_wildcard_matcher_top #(.MAX_PATTERN(32)) u_dut (.*);

  like_match_checker #(.MAX_PATTERN(32)) u_checker (.*);

  task automatic put_beat(action_e act, char_t c);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(6, 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    if ($urandom_range(40, 0) == 0) begin
      tx_burst = !tx_burst;
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_o != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_invert(logic v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  function automatic char_t pick_pattern_char();
    case ($urandom_range(7, 0))
      0, 1:    return CharAnyRun;
      2:       return CharAnyOne;
      3:       return char_t'($urandom_range(255, 0));
      default: return char_t'(8'h61 + $urandom_range(2, 0));
    endcase
  endfunction

  function automatic char_t pick_text_char();
    case ($urandom_range(5, 0))
      0:       return CharAnyRun;
      1:       return CharAnyOne;
      2:       return char_t'($urandom_range(255, 0));
      default: return char_t'(8'h61 + $urandom_range(2, 0));
    endcase
  endfunction

  task automatic run_query();
    char_t pat [$];
    char_t c;
    int    len;
    if ($urandom_range(3, 0) != 0) begin
      put_beat(ActClear, char_t'($urandom_range(255, 0)));
    end
    len = ($urandom_range(11, 0) == 0) ? $urandom_range(36, 28) : $urandom_range(6, 0);
    repeat (len) begin
      c = pick_pattern_char();
      pat = {pat, c};
      put_beat(ActAppend, c);
    end
    repeat ($urandom_range(3, 1)) begin
      if ($urandom_range(2, 0) != 0) begin
        foreach (pat[i]) begin
          if (pat[i] == CharAnyRun) begin
            repeat ($urandom_range(3, 0)) put_beat(ActText, pick_text_char());
          end else if (pat[i] == CharAnyOne) begin
            put_beat(ActText, pick_text_char());
          end else if ($urandom_range(14, 0) == 0) begin
            put_beat(ActText, pick_text_char());
          end else begin
            put_beat(ActText, pat[i]);
          end
        end
      end else begin
        repeat ($urandom_range(6, 0)) put_beat(ActText, pick_text_char());
      end
      put_beat(ActEnd, char_t'($urandom_range(255, 0)));
    end
  endtask

  task automatic run_random(int upto);
    while (beats_sent < upto) begin
      if ($urandom_range(9, 0) == 0) begin
        put_beat(action_e'($urandom_range(3, 0)), char_t'($urandom_range(255, 0)));
      end else begin
        run_query();
      end
    end
  endtask

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(6, 0);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if ($urandom_range(15, 0) == 0) begin
        rx_burst = !rx_burst;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_invert(1'b0);

    put_beat(ActEnd, 8'h00);
    put_beat(ActText, 8'h00);
    put_beat(ActEnd, 8'hFF);
    put_beat(ActAppend, CharAnyRun);
    put_beat(ActEnd, 8'h00);
    put_beat(ActText, 8'hFF);
    put_beat(ActText, CharAnyRun);
    put_beat(ActEnd, 8'h00);
    put_beat(ActClear, 8'hFF);
    put_beat(ActAppend, 8'h00);
    put_beat(ActAppend, CharAnyOne);
    put_beat(ActAppend, 8'hFF);
    put_beat(ActText, 8'h00);
    put_beat(ActText, CharAnyRun);
    put_beat(ActText, 8'hFF);
    put_beat(ActEnd, 8'h00);
    put_beat(ActText, 8'h00);
    put_beat(ActAppend, CharAnyRun);
    put_beat(ActText, 8'h00);
    put_beat(ActText, 8'h01);
    put_beat(ActText, 8'hFF);
    put_beat(ActEnd, 8'h00);
    put_beat(ActText, 8'h01);
    put_beat(ActEnd, 8'h00);
    settle();

    set_invert(1'b1);
    run_random(160);
    settle();
    set_invert(1'b0);
    run_random(300);
    settle();
    set_invert(1'b1);
    run_random(430);
    settle();
    set_invert(1'($urandom_range(1, 0)));
    run_random(540);
    settle();

    $display("Drove %0d input beats across %0d invert settings,", beats_sent, settings_used);
    $display("including overflowed patterns; %0d verdicts checked.", verdicts_o);
    if (fail_count_o == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
design/lwm_pkg.sv
design/lwm_nfa_step.sv
design/like_wildcard_matcher_top.sv
verif/like_match_checker.sv
verif/tb_like_wildcard_matcher_top.sv
